/* hw/rtl/crcfb_pkg.sv */
// crcfb_pkg: shared types, constants and the CRC-16/X.25 byte update for the
// crc16 frame builder. No dependencies.
`timescale 1ns / 1ps

package crcfb_pkg;

    localparam int          DATA_W         = 8;
    localparam int          MAX_RESULTS    = 6;
    localparam int          CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd6;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h8408;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_BUFFER_LEN = 2'd2
    } cfg_index_t;

    // item kind carried on tuser
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] cmd_id;
        logic [DATA_W-1:0] data_len;
        logic [DATA_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic              rejected;
        logic              frame_last;
        logic [DATA_W-1:0] out_byte;
    } result_t;

    // all beats caused by one item, entry 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]               cnt;
        result_t [MAX_RESULTS-1:0]      ent;
    } result_set_t;

    // reflected CRC-16, poly 0x8408, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crcfb_frame_core.sv */
// crcfb_frame_core: frame state (CRC, bytes left, open flag) and the
// combinational builder that turns one item into its set of output beats.
// Depends on crcfb_pkg.
`timescale 1ns / 1ps

module crcfb_frame_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  crcfb_pkg::item_t           item,
    input  logic                       item_fire,
    input  logic [7:0]                 start_byte,
    input  logic [7:0]                 end_byte,
    input  logic [7:0]                 buffer_len,
    output crcfb_pkg::result_set_t     res
);
    import crcfb_pkg::*;

    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic        frame_open_reg, frame_open_next;

    logic [15:0] crc_h1, crc_h2, crc_h3, crc_d;
    logic [15:0] fin_h, fin_d;
    logic        too_big;

    always_comb begin
        crc_h1  = crc_byte(CRC_INIT, start_byte);
        crc_h2  = crc_byte(crc_h1, item.cmd_id);
        crc_h3  = crc_byte(crc_h2, item.data_len);
        crc_d   = crc_byte(crc_reg, item.data_byte);
        fin_h   = ~crc_h3;
        fin_d   = ~crc_d;
        too_big = {1'b0, buffer_len} < (FRAME_OVERHEAD + {1'b0, item.data_len});
    end

    always_comb begin
        res             = '0;
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;

        if (item.op == OP_HEADER) begin
            // a header always abandons whatever was open
            frame_open_next = 1'b0;
            bytes_left_next = '0;
            if (too_big) begin
                res.cnt    = CNT_W'(1);
                res.ent[0] = '{rejected: 1'b1, frame_last: 1'b1, out_byte: '0};
            end else begin
                res.ent[0] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: start_byte};
                res.ent[1] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: item.cmd_id};
                res.ent[2] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: item.data_len};
                crc_next   = crc_h3;
                if (item.data_len == '0) begin
                    res.cnt    = CNT_W'(6);
                    res.ent[3] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: fin_h[15:8]};
                    res.ent[4] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: fin_h[7:0]};
                    res.ent[5] = '{rejected: 1'b0, frame_last: 1'b1, out_byte: end_byte};
                end else begin
                    res.cnt         = CNT_W'(3);
                    frame_open_next = 1'b1;
                    bytes_left_next = item.data_len;
                end
            end
        end else if (frame_open_reg && bytes_left_reg != '0) begin
            res.ent[0]      = '{rejected: 1'b0, frame_last: 1'b0, out_byte: item.data_byte};
            crc_next        = crc_d;
            bytes_left_next = bytes_left_reg - 8'd1;
            if (bytes_left_reg == 8'd1) begin
                res.cnt         = CNT_W'(4);
                res.ent[1] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: fin_d[15:8]};
                res.ent[2] = '{rejected: 1'b0, frame_last: 1'b0, out_byte: fin_d[7:0]};
                res.ent[3] = '{rejected: 1'b0, frame_last: 1'b1, out_byte: end_byte};
                frame_open_next = 1'b0;
            end else begin
                res.cnt = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= CRC_INIT;
            bytes_left_reg <= '0;
            frame_open_reg <= 1'b0;
        end else if (item_fire) begin
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

/* hw/rtl/crc16_frame_builder.sv */
// crc16_frame_builder: top level. Input register, config registers, frame
// core and a six-entry output beat buffer. Depends on crcfb_pkg, crcfb_frame_core.
//
//  channel | dir | beat contents
//  s_      | in  | tuser: op ; tdata: cmd_id[7:0], data_len[15:8], data_byte[23:16]
//  m_      | out | tdata: out_byte[7:0] ; tlast: frame_last ; tuser: rejected
//  cfg_    | in  | cfg_index: register index ; cfg_data: value
//
// An input beat is registered, then built combinationally into its output beats.
// Output runs at one beat per cycle while m_tready is high: a payload byte gives 1
// beat, a header 3 (6 with zero length, 1 if rejected), the last payload byte 4.
// Back-to-back payload beats flow at one per cycle with m_tready high; the input
// register takes a beat while output beats wait. Reset is synchronous, active low.
`timescale 1ns / 1ps

module crc16_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cmd_id, data_len, data_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // frame_last
    output logic        m_tuser,   // rejected
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import crcfb_pkg::*;

    logic [7:0] start_byte_reg, end_byte_reg, buffer_len_reg;

    logic        in_valid_reg;
    item_t       in_item_reg;

    result_t [MAX_RESULTS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    result_set_t res;
    logic        pop, buf_free, proc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= 8'd0;
            end_byte_reg   <= 8'd0;
            buffer_len_reg <= 8'd255;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data;
                CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                CFG_BUFFER_LEN: buffer_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign pop      = m_tvalid && m_tready;
    // buffer can take a new set when empty or its last beat leaves now
    assign buf_free = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_tready);
    assign proc     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= '{op: s_tuser, cmd_id: s_tdata[7:0],
                             data_len: s_tdata[15:8], data_byte: s_tdata[23:16]};
        end
    end

    crcfb_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (in_item_reg),
        .item_fire  (proc),
        .start_byte (start_byte_reg),
        .end_byte   (end_byte_reg),
        .buffer_len (buffer_len_reg),
        .res        (res)
    );

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (proc) begin
            buf_next = res.ent;
            cnt_next = res.cnt;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_tdata = buf_reg[0].out_byte;
    assign m_tlast = buf_reg[0].frame_last;
    assign m_tuser = buf_reg[0].rejected;

endmodule
